FILE: hdl/fccpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fccpid_pkg - shared definitions for the clamped four-channel PID
// Field widths, register indexes and the default channel count.
// ----------------------------------------------------------------------------
package fccpid_pkg;

	localparam int CHANNELS_DEF = 4;

	localparam int ChanW  = 2;   // channel field
	localparam int SpeedW = 16;  // measured / target
	localparam int DriveW = 16;
	localparam int GainW  = 16;  // unsigned Q8.8
	localparam int LimitW = 15;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam int ErrW  = SpeedW + 1;          // target - measured
	localparam int DErrW = ErrW + 1;            // change of error
	localparam int FracW = 8;
	localparam int AccW  = LimitW + FracW + 1;  // clamped integral, signed

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_LIMIT_INTEGRAL = 3'd3,
		REG_LIMIT_OUTPUT   = 3'd4
	} cfg_reg_t;

endpackage
`default_nettype wire

FILE: hdl/four_channel_clamped_pid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_clamped_pid - per-channel speed PID with clamped integral
// Datapath: input register, one pass of multiply, add and clamp, result register.
// Throughput: one item per cycle while result_stall does not hold the result register.
// Reset: gains, limits, integrators and previous errors all clear to zero.
// ----------------------------------------------------------------------------
module four_channel_clamped_pid #(
	parameter int CHANNELS = fccpid_pkg::CHANNELS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input items
	input  wire logic                              item_valid,
	output      logic                              item_stall,
	input  wire logic [fccpid_pkg::ChanW-1:0]      channel,
	input  wire logic signed [fccpid_pkg::SpeedW-1:0] measured,
	input  wire logic signed [fccpid_pkg::SpeedW-1:0] target,
	// results
	output      logic                              result_valid,
	input  wire logic                              result_stall,
	output      logic signed [fccpid_pkg::DriveW-1:0] drive,
	// configuration writes
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [fccpid_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [fccpid_pkg::CfgDataW-1:0]   cfg_data
);
	import fccpid_pkg::*;

	localparam int ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ExtW = (ChW > ChanW) ? ChW : ChanW;

	// configuration
	logic [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [LimitW-1:0] limit_integral_q, limit_output_q;

	// per-channel state
	logic signed [AccW-1:0] integral_acc_q [CHANNELS];
	logic signed [ErrW-1:0] previous_error_q [CHANNELS];

	// input register
	logic                     valid_s1;
	logic [ChanW-1:0]         channel_s1;
	logic signed [SpeedW-1:0] measured_s1, target_s1;

	// result register
	logic                     result_valid_q;
	logic signed [DriveW-1:0] drive_q;

	logic advance, update;
	logic ch_ok;
	logic [ExtW-1:0] ch_ext;
	logic [ChW-1:0]  ch_idx;

	logic signed [ErrW-1:0]   err, prev_rd;
	logic signed [AccW-1:0]   acc_rd;
	logic signed [DErrW-1:0]  derr;
	logic signed [ErrW-1:0]   gp_s, gi_s, gd_s;
	logic signed [2*ErrW-1:0] p_prod, i_prod;
	logic signed [2*DErrW-2:0] d_prod;
	logic signed [2*ErrW:0]   i_sum;
	logic signed [AccW-1:0]   lim_i_s, lim_o_s, i_clamp, s_clamp;
	logic signed [2*ErrW+2:0] total;
	logic signed [AccW-1:0]   s_shift;
	logic                     round_up;
	logic signed [DriveW-1:0] drive_c;

	// the input stage moves on when the result register is free or being emptied
	assign advance    = !result_valid_q || !result_stall;
	assign update     = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign drive        = drive_q;

	always_comb begin
		ch_ext = ExtW'(channel_s1);
		ch_idx = ch_ext[ChW-1:0];
		ch_ok  = 32'(channel_s1) < CHANNELS;
	end

	always_comb begin
		acc_rd  = ch_ok ? integral_acc_q[ch_idx] : '0;
		prev_rd = ch_ok ? previous_error_q[ch_idx] : '0;

		err  = ErrW'(target_s1) - ErrW'(measured_s1);
		derr = DErrW'(err) - DErrW'(prev_rd);

		gp_s = $signed({1'b0, gain_p_q});
		gi_s = $signed({1'b0, gain_i_q});
		gd_s = $signed({1'b0, gain_d_q});

		p_prod = (2*ErrW)'(err) * (2*ErrW)'(gp_s);
		i_prod = (2*ErrW)'(err) * (2*ErrW)'(gi_s);
		d_prod = (2*DErrW-1)'(derr) * (2*DErrW-1)'(gd_s);

		lim_i_s = $signed({1'b0, limit_integral_q, {FracW{1'b0}}});
		lim_o_s = $signed({1'b0, limit_output_q, {FracW{1'b0}}});

		// integrator: add increment, then saturate to the integral limit
		i_sum = (2*ErrW+1)'(acc_rd) + (2*ErrW+1)'(i_prod);
		if (i_sum > (2*ErrW+1)'(lim_i_s)) begin
			i_clamp = lim_i_s;
		end else if (i_sum < -(2*ErrW+1)'(lim_i_s)) begin
			i_clamp = -lim_i_s;
		end else begin
			i_clamp = $signed(i_sum[AccW-1:0]);
		end

		total = (2*ErrW+3)'(p_prod) + (2*ErrW+3)'(i_clamp) + (2*ErrW+3)'(d_prod);
		if (total > (2*ErrW+3)'(lim_o_s)) begin
			s_clamp = lim_o_s;
		end else if (total < -(2*ErrW+3)'(lim_o_s)) begin
			s_clamp = -lim_o_s;
		end else begin
			s_clamp = $signed(total[AccW-1:0]);
		end

		// drop the fraction, truncating toward zero
		s_shift  = s_clamp >>> FracW;
		round_up = s_clamp[AccW-1] && (|s_clamp[FracW-1:0]);
		drive_c  = ch_ok ? $signed(s_shift[DriveW-1:0] + DriveW'(round_up)) : '0;
	end

	// control, configuration and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			result_valid_q   <= 1'b0;
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			limit_integral_q <= '0;
			limit_output_q   <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				integral_acc_q[k]   <= '0;
				previous_error_q[k] <= '0;
			end
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (update && ch_ok) begin
				integral_acc_q[ch_idx]   <= i_clamp;
				previous_error_q[ch_idx] <= err;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GAIN_P:         gain_p_q <= cfg_data[GainW-1:0];
					REG_GAIN_I:         gain_i_q <= cfg_data[GainW-1:0];
					REG_GAIN_D:         gain_d_q <= cfg_data[GainW-1:0];
					REG_LIMIT_INTEGRAL: limit_integral_q <= cfg_data[LimitW-1:0];
					REG_LIMIT_OUTPUT:   limit_output_q <= cfg_data[LimitW-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			channel_s1  <= channel;
			measured_s1 <= measured;
			target_s1   <= target;
		end
		if (update) begin
			drive_q <= drive_c;
		end
	end

	// output never exceeds the output limit
	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |->
			(drive_q <= $signed({1'b0, limit_output_q}))
			&& (drive_q >= -$signed({1'b0, limit_output_q})))
		else $error("drive beyond output limit");

	// stored integrator stays within the integral limit
	a_acc_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(update && ch_ok) |=>
			(integral_acc_q[$past(ch_idx)] <= lim_i_s)
			&& (integral_acc_q[$past(ch_idx)] >= -lim_i_s))
		else $error("integrator beyond integral limit");

	// an unused channel gives a zero drive
	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(update && !ch_ok) |=> (result_valid_q && drive_q == '0))
		else $error("unused channel gave non-zero drive");

endmodule
`default_nettype wire
